// ----- design/m3inv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared constants for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

	// entries in one 3x3 matrix
	localparam int N_ENT = 9;

	// cofactor operand positions: adj[i] = m[A]*m[B] - m[C]*m[D]
	localparam int ADJ_IDX [N_ENT][4] = '{
		'{4, 8, 5, 7},
		'{2, 7, 1, 8},
		'{1, 5, 2, 4},
		'{5, 6, 3, 8},
		'{0, 8, 2, 6},
		'{2, 3, 0, 5},
		'{3, 7, 4, 6},
		'{1, 6, 0, 7},
		'{0, 4, 1, 3}
	};

	// adjugate entries that meet row 0 in the determinant expansion
	localparam int DET_ADJ [3] = '{0, 3, 6};

endpackage

// ----- design/m3inv_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_if
// Valid/ready channels for input matrices and inverse results.
// ----------------------------------------------------------------------------
interface m3inv_mat_if #(parameter int W = 32) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] m_r0c0, m_r0c1, m_r0c2;
	logic signed [W-1:0] m_r1c0, m_r1c1, m_r1c2;
	logic signed [W-1:0] m_r2c0, m_r2c1, m_r2c2;

	modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
		m_r2c0, m_r2c1, m_r2c2, input ready);
	modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
		m_r2c0, m_r2c1, m_r2c2, output ready);
endinterface

interface m3inv_inv_if #(parameter int W = 32) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] inv_r0c0, inv_r0c1, inv_r0c2;
	logic signed [W-1:0] inv_r1c0, inv_r1c1, inv_r1c2;
	logic signed [W-1:0] inv_r2c0, inv_r2c1, inv_r2c2;
	logic                singular;

	modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
		inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, input ready);
	modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
		inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, output ready);
endinterface

// ----- design/m3inv_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_div
// Pipelined unsigned restoring divider, one quotient bit per stage. The
// first stage flags quotients of 2^(W-1) or more; the rest build the
// W-1 low quotient bits.
// ----------------------------------------------------------------------------
module m3inv_div #(
	parameter int W  = 32,
	parameter int NW = 97,
	parameter int DW = 99
) (
	input  logic          clk,
	input  logic [W-1:0]  en,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	output logic [W-2:0]  q,
	output logic          ovf
);

	localparam int XW = ((NW > DW + W - 1) ? NW : DW + W - 1) + 1;

	logic [NW-1:0] rem_sd [W];
	logic [DW-1:0] d_sd   [W];
	logic [W-2:0]  q_sd   [W];
	logic          ovf_sd [W];

	// overflow check: n >= d * 2^(W-1)
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_sd[0] <= n;
			d_sd[0]   <= d;
			q_sd[0]   <= '0;
			ovf_sd[0] <= XW'(n) >= (XW'(d) << (W - 1));
		end
	end

	// one compare/subtract per stage, MSB first
	for (genvar j = 1; j < W; j++) begin : g_step
		localparam int B = W - 1 - j;
		logic [XW-1:0] dsh;
		logic          ge;
		assign dsh = XW'(d_sd[j-1]) << B;
		assign ge  = XW'(rem_sd[j-1]) >= dsh;

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_sd[j] <= ge ? NW'(XW'(rem_sd[j-1]) - dsh) : rem_sd[j-1];
				d_sd[j]   <= d_sd[j-1];
				q_sd[j]   <= q_sd[j-1] | ((W-1)'(ge) << B);
				ovf_sd[j] <= ovf_sd[j-1];
			end
		end
	end

	assign q   = q_sd[W-1];
	assign ovf = ovf_sd[W-1];

endmodule

// ----- design/matrix3x3_inverse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 fixed-point matrix inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
// Usage:
//  mat carries one matrix per beat: nine signed entries, FRAC_BITS fraction
//  bits, row-major. inv carries the nine inverse entries and a singular flag.
//  Each entry is cofactor * 2^(2*FRAC_BITS) / det, truncated toward zero and
//  saturated to ENTRY_WIDTH bits. For a zero determinant the input is echoed
//  with singular set.
//  Stages in order: input register, cofactor products, cofactors, determinant
//  partial products, determinant, magnitudes, then an overflow stage and one
//  stage per quotient bit in nine parallel dividers, then the output register.
//  Throughput is one matrix per cycle while the receiver is not stalling.
//  Every stage has its own valid bit and advances when it is empty or the next
//  stage advances, so a stalled receiver fills empty stages first and mat keeps
//  accepting until the pipeline is full. Nothing is dropped or repeated.
//  Reset clears all valid bits; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
	parameter int ENTRY_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input logic     clk,
	input logic     arst_n,
	m3inv_mat_if.sink   mat,
	m3inv_inv_if.source inv
);
	import m3inv_pkg::*;

	localparam int W   = ENTRY_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W;
	localparam int AW  = 2 * W + 1;
	localparam int DW  = 3 * W + 3;
	localparam int NW  = AW + 2 * F;
	localparam int DV0 = 6;
	localparam int NST = W + 7;

	// stage valid bits and advance enables
	logic [NST-1:0] v_q;
	logic [NST:0]   en;

	always_comb begin
		en[NST] = inv.ready;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= mat.valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign mat.ready = en[0];
	assign inv.valid = v_q[NST-1];

	// input beat as an array
	logic signed [W-1:0] m_in [N_ENT];
	assign m_in = '{mat.m_r0c0, mat.m_r0c1, mat.m_r0c2, mat.m_r1c0, mat.m_r1c1,
		mat.m_r1c2, mat.m_r2c0, mat.m_r2c1, mat.m_r2c2};

	logic signed [W-1:0]  m_s1 [N_ENT], m_s2 [N_ENT], m_s3 [N_ENT];
	logic signed [W-1:0]  m_s4 [N_ENT], m_s5 [N_ENT], m_s6 [N_ENT];
	logic signed [PW-1:0] prod_s2 [2*N_ENT];
	logic signed [AW-1:0] adj_s3 [N_ENT], adj_s4 [N_ENT], adj_s5 [N_ENT];
	logic signed [AW-1:0] plo_s4 [3], phi_s4 [3];
	logic signed [DW-1:0] det_s5;
	logic [NW-1:0]        n_s6 [N_ENT];
	logic [DW-1:0]        d_s6;
	logic [N_ENT-1:0]     neg_s6;
	logic                 sing_s6;

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (en[0]) m_s1 <= m_in;
	end

	// stage 2: cofactor products
	always_ff @(posedge clk) begin
		if (en[1]) begin
			m_s2 <= m_s1;
			for (int i = 0; i < N_ENT; i++) begin
				prod_s2[2*i]   <= m_s1[ADJ_IDX[i][0]] * m_s1[ADJ_IDX[i][1]];
				prod_s2[2*i+1] <= m_s1[ADJ_IDX[i][2]] * m_s1[ADJ_IDX[i][3]];
			end
		end
	end

	// stage 3: cofactors
	always_ff @(posedge clk) begin
		if (en[2]) begin
			m_s3 <= m_s2;
			for (int i = 0; i < N_ENT; i++) begin
				adj_s3[i] <= AW'(prod_s2[2*i]) - AW'(prod_s2[2*i+1]);
			end
		end
	end

	// stage 4: determinant partial products, cofactor split at bit W
	always_ff @(posedge clk) begin
		if (en[3]) begin
			m_s4   <= m_s3;
			adj_s4 <= adj_s3;
			for (int j = 0; j < 3; j++) begin
				plo_s4[j] <= m_s3[j] * $signed({1'b0, adj_s3[DET_ADJ[j]][W-1:0]});
				phi_s4[j] <= m_s3[j] * $signed(adj_s3[DET_ADJ[j]][AW-1:W]);
			end
		end
	end

	// stage 5: determinant
	logic signed [DW-1:0] term [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			term[j] = (DW'(phi_s4[j]) <<< W) + DW'(plo_s4[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			m_s5   <= m_s4;
			adj_s5 <= adj_s4;
			det_s5 <= term[0] + term[1] + term[2];
		end
	end

	// stage 6: magnitudes, scaled numerators, quotient signs
	always_ff @(posedge clk) begin
		if (en[5]) begin
			m_s6    <= m_s5;
			d_s6    <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			sing_s6 <= det_s5 == '0;
			for (int i = 0; i < N_ENT; i++) begin
				n_s6[i]   <= NW'(adj_s5[i][AW-1] ? AW'(-adj_s5[i]) : AW'(adj_s5[i]))
					<< (2 * F);
				neg_s6[i] <= adj_s5[i][AW-1] ^ det_s5[DW-1];
			end
		end
	end

	// dividers
	logic [W-2:0]     q_div [N_ENT];
	logic [N_ENT-1:0] ovf_div;

	for (genvar i = 0; i < N_ENT; i++) begin : g_div
		m3inv_div #(.W(W), .NW(NW), .DW(DW)) u_div (
			.clk (clk),
			.en  (en[DV0 +: W]),
			.n   (n_s6[i]),
			.d   (d_s6),
			.q   (q_div[i]),
			.ovf (ovf_div[i])
		);
	end

	// side data alongside the divider stages
	logic signed [W-1:0] m_sd    [W][N_ENT];
	logic [N_ENT-1:0]    neg_sd  [W];
	logic                sing_sd [W];

	always_ff @(posedge clk) begin
		if (en[DV0]) begin
			m_sd[0]    <= m_s6;
			neg_sd[0]  <= neg_s6;
			sing_sd[0] <= sing_s6;
		end
		for (int k = 1; k < W; k++) begin
			if (en[DV0+k]) begin
				m_sd[k]    <= m_sd[k-1];
				neg_sd[k]  <= neg_sd[k-1];
				sing_sd[k] <= sing_sd[k-1];
			end
		end
	end

	// output stage: sign, saturation, singular echo
	logic signed [W-1:0] res  [N_ENT];
	logic signed [W-1:0] inv_s7 [N_ENT];
	logic                sing_s7;

	always_comb begin
		for (int i = 0; i < N_ENT; i++) begin
			if (sing_sd[W-1]) begin
				res[i] = m_sd[W-1][i];
			end else if (ovf_div[i]) begin
				res[i] = neg_sd[W-1][i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else begin
				res[i] = neg_sd[W-1][i] ? -$signed({1'b0, q_div[i]})
					: $signed({1'b0, q_div[i]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			inv_s7  <= res;
			sing_s7 <= sing_sd[W-1];
		end
	end

	assign inv.inv_r0c0 = inv_s7[0];
	assign inv.inv_r0c1 = inv_s7[1];
	assign inv.inv_r0c2 = inv_s7[2];
	assign inv.inv_r1c0 = inv_s7[3];
	assign inv.inv_r1c1 = inv_s7[4];
	assign inv.inv_r1c2 = inv_s7[5];
	assign inv.inv_r2c0 = inv_s7[6];
	assign inv.inv_r2c1 = inv_s7[7];
	assign inv.inv_r2c2 = inv_s7[8];
	assign inv.singular = sing_s7;

endmodule

// ----- design/m3inv_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_chk
// Port-level checks for matrix3x3_inverse: stall behavior and beat count.
// ----------------------------------------------------------------------------
module m3inv_chk #(
	parameter int W = 32
) (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [W-1:0] out_e0,
	input logic         out_sing
);
	import m3inv_pkg::*;

	localparam int DEPTH = W + 7;
	localparam int CW    = $clog2(DEPTH + 2);

	// beats in flight
	logic [CW-1:0] cnt_q;
	logic          in_acc, out_acc;
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CW'(in_acc) - CW'(out_acc);
		end
	end

	// a waiting result holds (entry 0 and the singular flag are checked)
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_e0) && $stable(out_sing))
		else $error("result changed while stalled");

	// no result without a matrix in flight
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("result without input");

	// occupancy bounded by pipeline depth
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("too many beats in flight");

	// with no waiting result the input side is open
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// entry count per beat is fixed
	a_ent: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> N_ENT == 9)
		else $error("entry count mismatch");

endmodule

bind matrix3x3_inverse m3inv_chk #(.W(ENTRY_WIDTH)) u_m3inv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (mat.valid),
	.in_ready  (mat.ready),
	.out_valid (inv.valid),
	.out_ready (inv.ready),
	.out_e0    (inv.inv_r0c0),
	.out_sing  (inv.singular)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 fixed-point matrix inverse. Directed
// matrices (identity, scalings, singular forms, saturating extremes) are
// followed by random streams of wide, small, well-conditioned, integer and
// rank-deficient matrices. Every input beat is predicted with exact wide
// arithmetic and each result beat is compared in order, under random
// sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int W          = 32;
	localparam int N_ITEMS    = 1950;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYC  = 60;

	typedef logic [8:0][W-1:0] mat_t;
	typedef struct packed {
		mat_t ent;
		logic sing;
	} inv_beat_t;

	typedef enum int {MK_WIDE, MK_SMALL, MK_INT, MK_RANK2, MK_NEAR_ID} mat_kind_t;

	localparam logic signed [159:0] Q_MAX = 160'sd2147483647;
	localparam logic signed [159:0] Q_MIN = -Q_MAX - 160'sd1;
	localparam logic [W-1:0] ONE   = 32'h0001_0000;
	localparam logic [W-1:0] S_MAX = 32'h7fff_ffff;
	localparam logic [W-1:0] S_MIN = 32'h8000_0000;

	logic clk;
	logic arst_n;

	m3inv_mat_if #(.W(W)) mat_ch ();
	m3inv_inv_if #(.W(W)) inv_ch ();

	matrix3x3_inverse #(.ENTRY_WIDTH(W), .FRAC_BITS(16)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat_ch),
		.inv    (inv_ch)
	);

	inv_beat_t inv_expected_q[$];
	int        err_cnt    = 0;
	int        idle_cyc   = 0;
	logic      mat_rdy_s  = 1'b0;
	int        burst_left = 0;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// exact adjugate / determinant inverse
	function automatic inv_beat_t invert_matrix(input mat_t m);
		logic signed [159:0] e [9];
		logic signed [159:0] a [9];
		logic signed [159:0] det;
		logic signed [159:0] q;
		inv_beat_t r;
		for (int i = 0; i < 9; i++) e[i] = $signed(m[i]);
		a[0] = e[4] * e[8] - e[5] * e[7];
		a[1] = e[2] * e[7] - e[1] * e[8];
		a[2] = e[1] * e[5] - e[2] * e[4];
		a[3] = e[5] * e[6] - e[3] * e[8];
		a[4] = e[0] * e[8] - e[2] * e[6];
		a[5] = e[2] * e[3] - e[0] * e[5];
		a[6] = e[3] * e[7] - e[4] * e[6];
		a[7] = e[1] * e[6] - e[0] * e[7];
		a[8] = e[0] * e[4] - e[1] * e[3];
		det = e[0] * a[0] + e[1] * a[3] + e[2] * a[6];
		if (det == 0) begin
			r.ent  = m;
			r.sing = 1'b1;
		end else begin
			r.sing = 1'b0;
			for (int i = 0; i < 9; i++) begin
				q = (a[i] <<< 32) / det;
				if (q > Q_MAX)
					r.ent[i] = S_MAX;
				else if (q < Q_MIN)
					r.ent[i] = S_MIN;
				else
					r.ent[i] = q[W-1:0];
			end
		end
		return r;
	endfunction

	function automatic logic [W-1:0] rand_q(input int range_bits);
		logic [W-1:0] v;
		v = $urandom_range(0, (1 << range_bits) - 1);
		return v - (32'd1 << (range_bits - 1));
	endfunction

	function automatic mat_t rand_matrix(input mat_kind_t kind);
		mat_t m;
		for (int i = 0; i < 9; i++) begin
			case (kind)
				MK_WIDE:    m[i] = $urandom;
				MK_SMALL:   m[i] = rand_q($urandom_range(4, 20));
				MK_INT:     m[i] = ($urandom_range(0, 6) - 3) << 16;
				MK_RANK2:   m[i] = rand_q(19);
				default:    m[i] = ((i % 4 == 0) ? ONE : 32'd0) + rand_q(15);
			endcase
		end
		// third row as sum of the first two gives a zero determinant
		if (kind == MK_RANK2)
			for (int c = 0; c < 3; c++) m[6 + c] = m[c] + m[3 + c];
		return m;
	endfunction

	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	// send one matrix beat with bursty gaps
	task automatic send_matrix(input mat_t m);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				mat_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		mat_ch.valid  <= 1'b1;
		mat_ch.m_r0c0 <= m[0];
		mat_ch.m_r0c1 <= m[1];
		mat_ch.m_r0c2 <= m[2];
		mat_ch.m_r1c0 <= m[3];
		mat_ch.m_r1c1 <= m[4];
		mat_ch.m_r1c2 <= m[5];
		mat_ch.m_r2c0 <= m[6];
		mat_ch.m_r2c1 <= m[7];
		mat_ch.m_r2c2 <= m[8];
		do @(posedge clk); while (!mat_rdy_s);
		inv_expected_q.push_back(invert_matrix(m));
	endtask

	function automatic mat_t diag(input logic [W-1:0] a, b, c);
		mat_t m;
		m    = '0;
		m[0] = a;
		m[4] = b;
		m[8] = c;
		return m;
	endfunction

	task automatic test_regular;
		mat_t m;
		send_matrix(diag(ONE, ONE, ONE));
		send_matrix(diag(32'h0002_0000, 32'h0000_8000, 32'hfffc_0000));
		m = '0;
		m[1] = ONE; m[5] = ONE; m[6] = ONE;
		send_matrix(m);
		m = '0;
		m[0] = 32'h0002_0000; m[1] = ONE; m[3] = ONE; m[4] = 32'h0003_0000;
		m[8] = 32'hffff_0000; m[2] = 32'h0000_4000;
		send_matrix(m);
		send_matrix(diag(32'hffff_0000, 32'hffff_0000, 32'hffff_0000));
	endtask

	task automatic test_singular;
		mat_t m;
		send_matrix('0);
		m = '{default: S_MIN};
		send_matrix(m);
		m = '{default: S_MAX};
		send_matrix(m);
		m = '0;
		m[0] = ONE; m[4] = ONE;
		send_matrix(m);
		m = '{default: 32'hdead_beef};
		m[0] = 32'h1234_5678; m[3] = 32'h1234_5678; m[6] = 32'h1234_5678;
		send_matrix(m);
		send_matrix(rand_matrix(MK_RANK2));
	endtask

	task automatic test_saturation;
		mat_t m;
		send_matrix(diag(32'd1, 32'd1, 32'd1));
		send_matrix(diag(32'hffff_ffff, 32'd1, 32'd1));
		send_matrix(diag(S_MAX, S_MAX, S_MAX));
		send_matrix(diag(S_MIN, S_MIN, S_MIN));
		send_matrix(diag(S_MIN, S_MAX, 32'hffff_ffff));
		m = '{default: S_MAX};
		m[0] = S_MIN; m[4] = S_MIN; m[8] = S_MIN;
		send_matrix(m);
		m = '{default: 32'd1};
		m[0] = S_MAX; m[4] = S_MIN;
		send_matrix(m);
		m = '{default: S_MIN};
		m[1] = S_MAX; m[5] = 32'd0; m[6] = ONE;
		send_matrix(m);
	endtask

	task automatic test_random;
		int pick;
		mat_kind_t kind;
		for (int n = 0; n < N_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)      kind = MK_WIDE;
			else if (pick < 55) kind = MK_SMALL;
			else if (pick < 75) kind = MK_NEAR_ID;
			else if (pick < 90) kind = MK_INT;
			else                kind = MK_RANK2;
			send_matrix(rand_matrix(kind));
		end
	endtask

	// sample handshakes mid-cycle, check results
	always @(negedge clk) begin
		mat_t      got;
		inv_beat_t want;
		mat_rdy_s = mat_ch.ready;
		if ((mat_ch.valid && mat_ch.ready) || (inv_ch.valid && inv_ch.ready))
			idle_cyc = 0;
		else
			idle_cyc++;
		if (arst_n && inv_ch.valid && inv_ch.ready) begin
			got = {inv_ch.inv_r2c2, inv_ch.inv_r2c1, inv_ch.inv_r2c0,
				inv_ch.inv_r1c2, inv_ch.inv_r1c1, inv_ch.inv_r1c0,
				inv_ch.inv_r0c2, inv_ch.inv_r0c1, inv_ch.inv_r0c0};
			if (inv_expected_q.size() == 0) begin
				report("result beat with nothing outstanding");
			end else begin
				want = inv_expected_q.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== want.ent[i])
						report($sformatf("entry r%0dc%0d got %h want %h",
							i / 3, i % 3, got[i], want.ent[i]));
				if (inv_ch.singular !== want.sing)
					report($sformatf("singular got %b want %b",
						inv_ch.singular, want.sing));
			end
		end
	end

	// receiver backpressure: phases of always-ready, random, long stalls
	int   rx_phase = 0;
	int   rx_mode  = 0;
	int   rx_hold  = 0;
	logic rx_lvl   = 1'b1;
	always @(posedge clk) begin
		if (rx_phase == 0) begin
			rx_mode  = $urandom_range(0, 2);
			rx_phase = $urandom_range(50, 300);
		end
		rx_phase--;
		case (rx_mode)
			0: inv_ch.ready <= 1'b1;
			1: inv_ch.ready <= ($urandom_range(0, 9) < 7);
			default: begin
				if (rx_hold == 0) begin
					rx_lvl  = ~rx_lvl;
					rx_hold = rx_lvl ? $urandom_range(1, 20) : $urandom_range(1, 60);
				end
				rx_hold--;
				inv_ch.ready <= rx_lvl;
			end
		endcase
	end

	// watchdog on cycles with no beat on either side
	initial begin
		wait (idle_cyc >= IDLE_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	// main sequence
	initial begin
		arst_n        = 1'b0;
		mat_ch.valid  = 1'b0;
		mat_ch.m_r0c0 = '0; mat_ch.m_r0c1 = '0; mat_ch.m_r0c2 = '0;
		mat_ch.m_r1c0 = '0; mat_ch.m_r1c1 = '0; mat_ch.m_r1c2 = '0;
		mat_ch.m_r2c0 = '0; mat_ch.m_r2c1 = '0; mat_ch.m_r2c2 = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_regular();
		test_singular();
		test_saturation();
		test_random();

		mat_ch.valid <= 1'b0;
		wait (inv_expected_q.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
design/m3inv_pkg.sv
design/m3inv_if.sv
design/m3inv_div.sv
design/matrix3x3_inverse.sv
design/m3inv_chk.sv
tb/tb_top.sv
